>>> sv/ifpl_pkg.sv
// Package: sizes, action codes and node record type for the path length block
`timescale 1ns / 1ps
package ifpl_pkg;
    localparam int TREES    = 64;
    localparam int NODES    = 256;
    localparam int ATTRS    = 64;
    localparam int MAX_LEAF = 256;
    localparam int TREE_W   = $clog2(TREES);
    localparam int NODE_W   = $clog2(NODES);
    localparam int ATTR_W   = $clog2(ATTRS);
    localparam int SLOT_W   = TREE_W + NODE_W;
    localparam int LEAF_W   = $clog2(MAX_LEAF + 1);
    localparam int FACTOR_BITS = 32;

    localparam logic [1:0] ACT_NODE  = 2'd0;
    localparam logic [1:0] ACT_ATTR  = 2'd1;
    localparam logic [1:0] ACT_TABLE = 2'd2;
    localparam logic [1:0] ACT_SCORE = 2'd3;

    typedef struct packed {
        logic              internal;
        logic [8:0]        leaf_size;
        logic [7:0]        left;
        logic [7:0]        right;
        logic [5:0]        attr;
        logic [31:0]       threshold;
        logic              factor;
    } t_node;

    localparam int NODE_BITS = $bits(t_node);
endpackage

>>> sv/isolation_forest_path_length.sv
// Top level: isolation forest path length accumulator with tree walk sequencer
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_valid / o_ready           | action, node/attr/table fields
// out     | output    | o_valid / i_ready           | path_total, walk_overflow
// cfg     | input     | i_cfg_we (no wait)          | num_trees
// A write request goes from accept straight to its result. A score request walks
// every counted tree from its root: each level needs a node memory read, an
// attribute memory read and one compare step, each leaf a path table read, and
// each tree a start and an add step.
// Reset clears control state and num_trees to 1; memories hold anything until
// written. The block takes no request until its result has been taken.
`timescale 1ns / 1ps
module isolation_forest_path_length (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_tree_index,
    input  logic [7:0]  i_node_index,
    input  logic        i_node_internal,
    input  logic [8:0]  i_leaf_size,
    input  logic [7:0]  i_left_child,
    input  logic [7:0]  i_right_child,
    input  logic [5:0]  i_attr_index,
    input  logic signed [31:0] i_split_value,
    input  logic        i_split_is_factor,
    input  logic signed [31:0] i_data_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_path_total,
    output logic        o_walk_overflow
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TREE = 3'd1;
    localparam logic [2:0] S_NODE = 3'd2;
    localparam logic [2:0] S_ATTR = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;
    localparam logic [2:0] S_LEAF = 3'd5;
    localparam logic [2:0] S_ADD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_num_trees;
    logic [6:0]  r_tree, n_tree;
    logic [ifpl_pkg::NODE_W-1:0] r_node, n_node;
    logic [ifpl_pkg::NODE_W:0]   r_depth, n_depth;
    logic [32:0] r_sum, n_sum;
    logic        r_over, n_over;
    logic [31:0] r_leaf_add, n_leaf_add;

    logic        w_accept;
    logic        w_node_we, w_attr_we, w_tab_we;
    ifpl_pkg::t_node w_node_wr, w_node_rd;
    logic [ifpl_pkg::SLOT_W-1:0] w_node_raddr;
    logic [31:0] w_attr_rd;
    logic [23:0] w_tab_rd;
    logic [ifpl_pkg::LEAF_W-1:0] w_tab_raddr;
    logic [6:0]  w_count;
    logic        w_left;
    logic signed [31:0] w_attr_val;
    logic [31:0] w_depth_q;
    logic [33:0] w_add;
    logic [ifpl_pkg::NODE_W-1:0] w_next;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_node_we = w_accept && (i_action == ifpl_pkg::ACT_NODE);
    assign w_attr_we = w_accept && (i_action == ifpl_pkg::ACT_ATTR);
    assign w_tab_we  = w_accept && (i_action == ifpl_pkg::ACT_TABLE)
                       && (i_leaf_size <= 9'(ifpl_pkg::MAX_LEAF));

    assign w_node_wr = '{internal: i_node_internal, leaf_size: i_leaf_size,
                         left: i_left_child, right: i_right_child, attr: i_attr_index,
                         threshold: i_split_value, factor: i_split_is_factor};
    assign w_node_raddr = {r_tree[ifpl_pkg::TREE_W-1:0], r_node};
    assign w_tab_raddr  = (w_node_rd.leaf_size > 9'(ifpl_pkg::MAX_LEAF))
                          ? ifpl_pkg::LEAF_W'(ifpl_pkg::MAX_LEAF)
                          : w_node_rd.leaf_size;

    ifpl_ram #(.WIDTH(ifpl_pkg::NODE_BITS), .DEPTH(ifpl_pkg::TREES * ifpl_pkg::NODES))
    u_node (.i_clk, .i_we(w_node_we), .i_waddr({i_tree_index, i_node_index}),
            .i_wdata(w_node_wr), .i_raddr(w_node_raddr), .o_rdata(w_node_rd));
    ifpl_ram #(.WIDTH(32), .DEPTH(ifpl_pkg::ATTRS))
    u_attr (.i_clk, .i_we(w_attr_we), .i_waddr(i_attr_index),
            .i_wdata(i_data_value), .i_raddr(w_node_rd.attr), .o_rdata(w_attr_rd));
    ifpl_ram #(.WIDTH(24), .DEPTH(ifpl_pkg::MAX_LEAF + 1))
    u_tab (.i_clk, .i_we(w_tab_we), .i_waddr(i_leaf_size),
           .i_wdata(i_data_value[23:0]), .i_raddr(w_tab_raddr), .o_rdata(w_tab_rd));

    // branch decision: factor level bit lookup or signed threshold compare
    assign w_attr_val = w_attr_rd;
    always_comb begin
        if (w_node_rd.factor) begin
            if (w_attr_val < 32'sd1 || w_attr_val > 32'sd32) begin
                w_left = 1'b0;
            end else begin
                w_left = w_node_rd.threshold[5'(w_attr_val - 32'sd1)];
            end
        end else begin
            w_left = $signed(w_attr_rd) < $signed(w_node_rd.threshold);
        end
    end
    assign w_next = w_left ? w_node_rd.left : w_node_rd.right;

    assign w_count   = (r_num_trees > 7'(ifpl_pkg::TREES)) ? 7'(ifpl_pkg::TREES) : r_num_trees;
    assign w_depth_q = {7'd0, r_depth, 16'd0};
    assign w_add     = {1'b0, r_sum} + {2'b0, w_depth_q} + {2'b0, r_leaf_add};

    // sequencer
    always_comb begin
        n_state = r_state; n_tree = r_tree; n_node = r_node; n_depth = r_depth;
        n_sum = r_sum; n_over = r_over; n_leaf_add = r_leaf_add;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sum = '0; n_over = 1'b0; n_tree = '0;
                    n_state = (i_action == ifpl_pkg::ACT_SCORE) ? S_TREE : S_OUT;
                end
            end
            S_TREE: begin
                n_node = '0; n_depth = '0;
                n_state = (r_tree < w_count) ? S_NODE : S_OUT;
            end
            S_NODE: n_state = S_ATTR;
            S_ATTR: begin
                if (!w_node_rd.internal) begin
                    n_state = S_LEAF;
                end else if (r_depth >= (ifpl_pkg::NODE_W+1)'(ifpl_pkg::NODES)) begin
                    n_over = 1'b1; n_leaf_add = '0; n_state = S_ADD;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_depth = r_depth + 1'b1;
                n_node = w_next;
                n_state = S_NODE;
            end
            S_LEAF: begin
                n_leaf_add = {8'd0, w_tab_rd};
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sum = w_add[33:32] != 2'b0 ? {1'b0, 32'hFFFF_FFFF} : {1'b0, w_add[31:0]};
                n_tree = r_tree + 1'b1;
                n_state = S_TREE;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_num_trees <= 7'd1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_num_trees <= i_cfg_wdata;
        end
        r_tree <= n_tree; r_node <= n_node; r_depth <= n_depth;
        r_sum <= n_sum; r_over <= n_over; r_leaf_add <= n_leaf_add;
    end

    assign o_valid         = (r_state == S_OUT);
    assign o_path_total    = r_sum[31:0];
    assign o_walk_overflow = r_over;
endmodule

>>> sv/ifpl_ram.sv
// Generic single-port-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ifpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> verif/testbench.sv
// Testbench for the isolation forest path length block: checks every result against a forest walk
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [1:0]  action;
        logic [5:0]  tree_index;
        logic [7:0]  node_index;
        logic        node_internal;
        logic [8:0]  leaf_size;
        logic [7:0]  left_child;
        logic [7:0]  right_child;
        logic [5:0]  attr_index;
        logic [31:0] split_value;
        logic        split_is_factor;
        logic [31:0] data_value;
    } t_request;

    typedef struct {
        logic [31:0] path_total;
        logic        walk_overflow;
    } t_score;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = '0;
    logic [5:0]  i_tree_index = '0;
    logic [7:0]  i_node_index = '0;
    logic        i_node_internal = 1'b0;
    logic [8:0]  i_leaf_size = '0;
    logic [7:0]  i_left_child = '0;
    logic [7:0]  i_right_child = '0;
    logic [5:0]  i_attr_index = '0;
    logic signed [31:0] i_split_value = '0;
    logic        i_split_is_factor = 1'b0;
    logic signed [31:0] i_data_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_path_total;
    logic        o_walk_overflow;

    // Shadow copy of the block's stores and register
    ifpl_pkg::t_node forest[ifpl_pkg::TREES*ifpl_pkg::NODES];
    bit          node_loaded[ifpl_pkg::TREES*ifpl_pkg::NODES];
    logic [31:0] sample_attr[ifpl_pkg::ATTRS];
    logic [23:0] avg_path[ifpl_pkg::MAX_LEAF+1];
    logic [6:0]  trees_walked;

    t_score      pending_scores[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    isolation_forest_path_length dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_tree_index(i_tree_index), .i_node_index(i_node_index),
        .i_node_internal(i_node_internal), .i_leaf_size(i_leaf_size),
        .i_left_child(i_left_child), .i_right_child(i_right_child),
        .i_attr_index(i_attr_index), .i_split_value(i_split_value),
        .i_split_is_factor(i_split_is_factor), .i_data_value(i_data_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_path_total(o_path_total), .o_walk_overflow(o_walk_overflow)
    );

    always #4 i_clk = ~i_clk;

    // Safety stop
    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Decide the branch at one internal node
    function automatic bit takes_left(input ifpl_pkg::t_node n);
        logic signed [31:0] raw;
        raw = sample_attr[n.attr];
        if (n.factor) begin
            if (raw < 1 || raw > ifpl_pkg::FACTOR_BITS)
                return 1'b0;
            return n.threshold[raw - 1];
        end
        return raw < $signed(n.threshold);
    endfunction

    // Sum depth plus c(leaf size) over the walked trees
    function automatic t_score score_forest();
        t_score     res;
        longint     sum;
        longint     depth;
        int         count;
        int         node;
        int         sz;
        ifpl_pkg::t_node n;
        sum = 0;
        res.walk_overflow = 1'b0;
        count = (trees_walked > ifpl_pkg::TREES) ? ifpl_pkg::TREES : trees_walked;
        for (int t = 0; t < count; t++) begin
            node = 0;
            depth = 0;
            forever begin
                n = forest[t*ifpl_pkg::NODES + node];
                if (!n.internal) begin
                    sz = (n.leaf_size > ifpl_pkg::MAX_LEAF) ? ifpl_pkg::MAX_LEAF : n.leaf_size;
                    sum += (depth << 16) + avg_path[sz];
                    break;
                end
                if (depth >= ifpl_pkg::NODES) begin
                    res.walk_overflow = 1'b1;
                    sum += depth << 16;
                    break;
                end
                depth++;
                node = takes_left(n) ? n.left : n.right;
            end
            if (sum > 64'hFFFF_FFFF)
                sum = 64'hFFFF_FFFF;
        end
        res.path_total = sum[31:0];
        return res;
    endfunction

    // Apply one accepted request to the shadow stores and return its result
    function automatic t_score apply_request(input t_request r);
        t_score res;
        int     slot;
        res = '{32'd0, 1'b0};
        case (r.action)
            ifpl_pkg::ACT_NODE: begin
                slot = r.tree_index * ifpl_pkg::NODES + r.node_index;
                forest[slot] = '{r.node_internal, r.leaf_size, r.left_child, r.right_child,
                                 r.attr_index, r.split_value, r.split_is_factor};
                node_loaded[slot] = 1'b1;
            end
            ifpl_pkg::ACT_ATTR: sample_attr[r.attr_index] = r.data_value;
            ifpl_pkg::ACT_TABLE: begin
                if (r.leaf_size <= ifpl_pkg::MAX_LEAF)
                    avg_path[r.leaf_size] = r.data_value[23:0];
            end
            default: res = score_forest();
        endcase
        return res;
    endfunction

    // Drive one request, hold it until taken, then maybe idle
    task automatic send_request(input t_request r);
        i_action <= r.action;
        i_tree_index <= r.tree_index;
        i_node_index <= r.node_index;
        i_node_internal <= r.node_internal;
        i_leaf_size <= r.leaf_size;
        i_left_child <= r.left_child;
        i_right_child <= r.right_child;
        i_attr_index <= r.attr_index;
        i_split_value <= r.split_value;
        i_split_is_factor <= r.split_is_factor;
        i_data_value <= r.data_value;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_scores.push_back(apply_request(r));
        // Drop valid only for an idle gap; the next request replaces the payload otherwise
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic t_request random_request();
        t_request r;
        r.action = 2'($urandom_range(3));
        r.tree_index = 6'($urandom);
        r.node_index = 8'($urandom);
        r.node_internal = 1'($urandom);
        r.leaf_size = 9'($urandom);
        r.left_child = 8'($urandom);
        r.right_child = 8'($urandom);
        r.attr_index = 6'($urandom);
        r.split_value = $urandom;
        r.split_is_factor = 1'($urandom);
        r.data_value = $urandom;
        return r;
    endfunction

    // Pick a loaded child below the node so that every walk ends at a leaf
    function automatic logic [7:0] pick_child(input int tree, input int idx);
        int c;
        for (int k = 0; k < 4; k++) begin
            c = $urandom_range(ifpl_pkg::NODES - 1, idx + 1);
            if (node_loaded[tree*ifpl_pkg::NODES + c])
                return 8'(c);
        end
        return 8'(ifpl_pkg::NODES - 1);
    endfunction

    // Node write that keeps the tree well formed; node 255 always stays a leaf
    function automatic t_request node_request(input int tree, input int idx, input bit leaf);
        t_request r;
        r = random_request();
        r.action = ifpl_pkg::ACT_NODE;
        r.tree_index = 6'(tree);
        r.node_index = 8'(idx);
        r.node_internal = !leaf && idx != ifpl_pkg::NODES - 1 && $urandom_range(99) < 65;
        if (r.node_internal) begin
            r.left_child = pick_child(tree, idx);
            r.right_child = pick_child(tree, idx);
            if (r.split_is_factor == 1'b0 && $urandom_range(1))
                r.split_value = $urandom_range(20 << 16) - (10 << 16);
        end
        return r;
    endfunction

    // Attribute values: half factor levels around the valid range
    function automatic t_request attr_request(input int slot);
        t_request r;
        r = random_request();
        r.action = ifpl_pkg::ACT_ATTR;
        r.attr_index = 6'(slot);
        if ($urandom_range(1))
            r.data_value = $urandom_range(35) - 1;
        else if ($urandom_range(1))
            r.data_value = $urandom_range(20 << 16) - (10 << 16);
        return r;
    endfunction

    function automatic t_request score_request();
        t_request r;
        r = random_request();
        r.action = ifpl_pkg::ACT_SCORE;
        return r;
    endfunction

    // Drop valid and wait until every result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tree_count(input logic [6:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        trees_walked = value;
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_score want;
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_scores.pop_front();
                if (o_path_total !== want.path_total)
                    report_mismatch($sformatf("path_total %h, expected %h",
                                              o_path_total, want.path_total));
                if (o_walk_overflow !== want.walk_overflow)
                    report_mismatch($sformatf("walk_overflow %b, expected %b",
                                              o_walk_overflow, want.walk_overflow));
            end
        end
    end

    // Fill table, attributes and a small root part of every tree before any score
    task automatic test_load_tables();
        t_request r;
        for (int i = 0; i <= ifpl_pkg::MAX_LEAF; i++) begin
            r = random_request();
            r.action = ifpl_pkg::ACT_TABLE;
            r.leaf_size = 9'(i);
            send_request(r);
        end
        r.leaf_size = 9'd511;
        send_request(r);
        r.leaf_size = 9'(ifpl_pkg::MAX_LEAF + 1);
        send_request(r);
        for (int i = 0; i < ifpl_pkg::ATTRS; i++)
            send_request(attr_request(i));
        for (int t = 0; t < ifpl_pkg::TREES; t++) begin
            send_request(node_request(t, ifpl_pkg::NODES - 1, 1'b1));
            for (int i = 3; i >= 0; i--)
                send_request(node_request(t, i, i == 3));
        end
    endtask

    // Extremes of thresholds, factor levels and leaf sizes on tree 0
    task automatic test_directed_cases();
        t_request r;
        int levels[6] = '{0, 1, 32, 33, -1, 'h8000_0000};
        write_tree_count(7'd1);
        r = node_request(0, 0, 1'b0);
        r.node_internal = 1'b1;
        r.attr_index = 6'd63;
        r.split_is_factor = 1'b1;
        r.split_value = 32'h8000_0001;
        r.left_child = 8'd255;
        r.right_child = 8'd254;
        send_request(r);
        r = node_request(0, 254, 1'b1);
        r.leaf_size = 9'd511;
        send_request(r);
        foreach (levels[i]) begin
            r = attr_request(63);
            r.data_value = levels[i];
            send_request(r);
            send_request(score_request());
        end
        // Numeric node against both ends of the threshold range
        r = node_request(0, 0, 1'b0);
        r.node_internal = 1'b1;
        r.attr_index = 6'd63;
        r.split_is_factor = 1'b0;
        r.split_value = 32'h7FFF_FFFF;
        r.left_child = 8'd255;
        r.right_child = 8'd254;
        send_request(r);
        r = attr_request(63);
        r.data_value = 32'h8000_0000;
        send_request(r);
        send_request(score_request());
        r.data_value = 32'h7FFF_FFFF;
        send_request(r);
        send_request(score_request());
    endtask

    // Tree count at and beyond its ends
    task automatic test_tree_count_extremes();
        logic [6:0] counts[5] = '{7'd0, 7'd64, 7'd65, 7'd127, 7'd1};
        foreach (counts[i]) begin
            write_tree_count(counts[i]);
            send_request(score_request());
        end
    endtask

    // Self loop at the root: walk is stopped and flagged
    task automatic test_long_walk();
        t_request r;
        write_tree_count(7'd2);
        r = node_request(0, 0, 1'b0);
        r.node_internal = 1'b1;
        r.left_child = 8'd0;
        r.right_child = 8'd0;
        send_request(r);
        send_request(score_request());
        send_request(node_request(0, 0, 1'b0));
        send_request(score_request());
    endtask

    // Mostly well-formed writes and scores with random content
    task automatic test_random_traffic(input int count);
        t_request r;
        int       idx;
        int       pick;
        write_tree_count(7'($urandom_range(127)));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                idx = ($urandom_range(9) < 7) ? $urandom_range(15)
                                              : $urandom_range(ifpl_pkg::NODES - 1);
                r = node_request($urandom_range(ifpl_pkg::TREES - 1), idx, 1'b0);
            end else if (pick < 55) begin
                r = attr_request($urandom_range(ifpl_pkg::ATTRS - 1));
            end else if (pick < 70) begin
                r = random_request();
                r.action = ifpl_pkg::ACT_TABLE;
            end else begin
                r = score_request();
            end
            send_request(r);
            if (i % 60 == 59)
                write_tree_count(7'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                             : $urandom_range(12)));
        end
    endtask

    initial begin
        for (int i = 0; i < ifpl_pkg::TREES*ifpl_pkg::NODES; i++)
            node_loaded[i] = 1'b0;
        trees_walked = 7'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_tables();
        test_directed_cases();
        test_tree_count_extremes();
        test_long_walk();

        send_idle_pct = 27;
        recv_idle_pct = 78;
        test_random_traffic(110);
        send_idle_pct = 78;
        recv_idle_pct = 27;
        test_random_traffic(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> isolation_forest_path_length.f
sv/ifpl_pkg.sv
sv/ifpl_ram.sv
sv/isolation_forest_path_length.sv
verif/testbench.sv
